// File: rtl/triangle_quality_metrics_unit_defines.svh
// Assertion macros used by the top-level RTL file of the triangle quality unit.
`ifndef TRIANGLE_QUALITY_METRICS_UNIT_DEFINES_SVH
`define TRIANGLE_QUALITY_METRICS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQM_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TQM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tqm_pkg.sv
package tqm_pkg;

  localparam int TQM_COORD_W   = 20;
  localparam int TQM_DIFF_W    = 21;
  localparam int TQM_PROD_W    = 42;
  localparam int TQM_CROSS_W   = 43;
  localparam int TQM_SUM_W     = 22;
  localparam int TQM_CEN_W     = 22;
  localparam int TQM_CM_W      = 24;
  localparam int TQM_CP_W      = 48;
  localparam logic [23:0] TQM_RECIP3 = 24'hAAAAAB;
  localparam int TQM_RECIP3_SHIFT = 25;
  localparam int TQM_EDGE_W    = 42;
  localparam int TQM_SQ_W      = 86;
  localparam int TQM_ROOT_W    = 43;
  localparam int TQM_LEN_W     = 29;
  localparam int TQM_PER_W     = 31;
  localparam logic [17:0] TQM_QUALITY_K = 18'd227023;
  localparam int TQM_QBITS     = 17;
  localparam logic [16:0] TQM_QUALITY_ONE = 17'h10000;
  localparam int TQM_DEN_W     = 62;
  localparam int TQM_NUM_W     = 78;
  localparam int TQM_REM_W     = TQM_DEN_W + TQM_QBITS;
  localparam int TQM_AREA_W    = 44;
  localparam int TQM_DIV_STAGES = TQM_QBITS + 1;
  localparam int TQM_FRONT_STAGES = 7;
  localparam int TQM_PRE_STAGES = 2;
  localparam int TQM_PIPE_DEPTH = TQM_FRONT_STAGES + TQM_ROOT_W + TQM_PRE_STAGES
                                  + TQM_DIV_STAGES;
  localparam int TQM_IN_W      = 184;
  localparam int TQM_OUT_W     = 128;
  localparam int TQM_USER_W    = 2;
  localparam int TQM_USER_LOWQ = 0;
  localparam int TQM_USER_DEGEN = 1;

  typedef logic [TQM_CEN_W-1:0] tqm_cen_t;

  typedef struct packed {
    tqm_cen_t [2:0]          cen;
    logic [TQM_ROOT_W-1:0]   twice;
    logic                    degen;
  } tqm_side_t;

endpackage

// File: rtl/triangle_quality_metrics_unit.sv
// Triangle quality metrics unit.
// An item on the in_ stream carries the three vertices of one triangle; for each
// item the out_ stream delivers one result: the centroid in quarter grid units,
// twice the area, the shape quality in Q1.16 and two flags in out_tuser.
// The cfg_ channel writes the quality threshold; it is always ready and is
// meant to be written while no item is in flight.
// The block is a 71-stage pipeline; it accepts one item every cycle while the
// output is not stalled.
// Most of the stages are in the two bit-per-stage units: the 43-stage square root
// (area and edge lengths) and the 18-stage quality divider.
// When the receiver holds out_tready low while a result waits, the whole
// pipeline freezes and in_tready drops in the same cycle; nothing is lost.
// A synchronous reset clears all valid bits and sets the threshold to zero;
// data registers are not reset.
`include "triangle_quality_metrics_unit_defines.svh"

module triangle_quality_metrics_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz (20 bits each), then 4 zero bits
  input  logic [tqm_pkg::TQM_IN_W-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // centroid_x, centroid_y, centroid_z (22 each), twice_area (44),
  // quality (17), then 1 zero bit
  output logic [tqm_pkg::TQM_OUT_W-1:0]  out_tdata,
  // low_quality, degenerate
  output logic [tqm_pkg::TQM_USER_W-1:0] out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tqm_pkg::TQM_QBITS-1:0]  cfg_data
);
  import tqm_pkg::*;

  logic                 en;
  logic [TQM_PIPE_DEPTH-1:0] vld_r;
  logic [TQM_QBITS-1:0] thr_r;

  logic [TQM_COORD_W-1:0] pa [3];
  logic [TQM_COORD_W-1:0] pb [3];
  logic [TQM_COORD_W-1:0] pc [3];

  logic signed [TQM_DIFF_W-1:0] u1_r [3];
  logic signed [TQM_DIFF_W-1:0] v1_r [3];
  logic signed [TQM_DIFF_W-1:0] w1_r [3];
  logic [TQM_SUM_W-1:0]         csum1_r [3];

  logic signed [TQM_PROD_W-1:0] pc2_r [6];
  logic [TQM_PROD_W-1:0]        esq2_r [3][3];
  logic [TQM_CM_W-1:0]          cm2_r [3];
  logic                         cneg2_r [3];

  logic [TQM_CROSS_W-1:0] cd3_r [3];
  logic [TQM_EDGE_W-1:0]  es3_r [3];
  logic [TQM_CP_W-1:0]    cp3_r [3];
  logic                   cneg3_r [3];

  logic [TQM_CROSS_W-1:0] cn4_r [3];
  logic [TQM_EDGE_W-1:0]  es4_r [3];
  tqm_cen_t               cen4_r [3];

  logic [41:0]           hh5_r [3];
  logic [42:0]           hl5_r [3];
  logic [43:0]           ll5_r [3];
  logic [TQM_EDGE_W-1:0] es5_r [3];
  tqm_cen_t              cen5_r [3];

  logic [TQM_SQ_W-1:0]   csq6_r [3];
  logic [TQM_EDGE_W-1:0] es6_r [3];
  tqm_cen_t              cen6_r [3];

  logic [TQM_SQ_W-1:0]   s7_r;
  logic [TQM_EDGE_W-1:0] es7_r [3];
  tqm_cen_t [2:0]        cen7_r;

  tqm_cen_t [2:0]        cen_dly_r [TQM_ROOT_W];
  logic [TQM_ROOT_W-1:0] area_root;
  logic [TQM_ROOT_W-1:0] len_root [3];

  logic [TQM_PER_W-1:0] per1_r;
  logic [39:0]          klo1_r;
  logic [38:0]          khi1_r;
  tqm_side_t            side1_r;

  logic [TQM_DEN_W-1:0] ak_sum;
  logic [TQM_DEN_W-1:0] den2_r;
  logic [TQM_NUM_W-1:0] num2_r;
  tqm_side_t            side2_r;

  tqm_side_t            side_dly_r [TQM_DIV_STAGES];
  logic [TQM_QBITS-1:0] quo;
  logic [TQM_QBITS-1:0] qual;

  logic                  out_tvalid_r;
  tqm_cen_t [2:0]        cen_o_r;
  logic [TQM_AREA_W-1:0] area_o_r;
  logic [TQM_QBITS-1:0]  quality_r;
  logic                  lowq_r;
  logic                  degen_r;

  // The pipeline moves as one; it stops only while a result waits unread.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= {vld_r[TQM_PIPE_DEPTH-2:0], in_tvalid};
      out_tvalid_r <= vld_r[TQM_PIPE_DEPTH-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = in_tdata[k*TQM_COORD_W +: TQM_COORD_W];
      pb[k] = in_tdata[(k+3)*TQM_COORD_W +: TQM_COORD_W];
      pc[k] = in_tdata[(k+6)*TQM_COORD_W +: TQM_COORD_W];
    end
  end

  // Front stages: edge vectors, cross product, squared lengths, centroid.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u1_r[k] <= {pb[k][TQM_COORD_W-1], pb[k]} - {pa[k][TQM_COORD_W-1], pa[k]};
        v1_r[k] <= {pc[k][TQM_COORD_W-1], pc[k]} - {pa[k][TQM_COORD_W-1], pa[k]};
        w1_r[k] <= {pc[k][TQM_COORD_W-1], pc[k]} - {pb[k][TQM_COORD_W-1], pb[k]};
        csum1_r[k] <= {{2{pa[k][TQM_COORD_W-1]}}, pa[k]}
                    + {{2{pb[k][TQM_COORD_W-1]}}, pb[k]}
                    + {{2{pc[k][TQM_COORD_W-1]}}, pc[k]};
      end

      pc2_r[0] <= u1_r[1] * v1_r[2];
      pc2_r[1] <= u1_r[2] * v1_r[1];
      pc2_r[2] <= u1_r[2] * v1_r[0];
      pc2_r[3] <= u1_r[0] * v1_r[2];
      pc2_r[4] <= u1_r[0] * v1_r[1];
      pc2_r[5] <= u1_r[1] * v1_r[0];
      for (int k = 0; k < 3; k++) begin
        esq2_r[0][k] <= u1_r[k] * u1_r[k];
        esq2_r[1][k] <= w1_r[k] * w1_r[k];
        esq2_r[2][k] <= v1_r[k] * v1_r[k];
        // Magnitude of four times the sum, plus one, for rounding to nearest.
        cm2_r[k]   <= csum1_r[k][TQM_SUM_W-1] ?
                      (~{csum1_r[k], 2'b00} + TQM_CM_W'(2)) :
                      ({csum1_r[k], 2'b00} + TQM_CM_W'(1));
        cneg2_r[k] <= csum1_r[k][TQM_SUM_W-1];
      end

      for (int k = 0; k < 3; k++) begin
        cd3_r[k]   <= {pc2_r[2*k][TQM_PROD_W-1], pc2_r[2*k]}
                    - {pc2_r[2*k+1][TQM_PROD_W-1], pc2_r[2*k+1]};
        es3_r[k]   <= esq2_r[k][0] + esq2_r[k][1] + esq2_r[k][2];
        cp3_r[k]   <= cm2_r[k] * TQM_RECIP3;
        cneg3_r[k] <= cneg2_r[k];
      end

      for (int k = 0; k < 3; k++) begin
        cn4_r[k]  <= cd3_r[k][TQM_CROSS_W-1] ? (TQM_CROSS_W'(0) - cd3_r[k]) : cd3_r[k];
        es4_r[k]  <= es3_r[k];
        cen4_r[k] <= cneg3_r[k] ?
                     (TQM_CEN_W'(0) - cp3_r[k][TQM_RECIP3_SHIFT +: TQM_CEN_W]) :
                     cp3_r[k][TQM_RECIP3_SHIFT +: TQM_CEN_W];
      end

      // Square of each cross component, split into high and low halves.
      for (int k = 0; k < 3; k++) begin
        hh5_r[k]  <= cn4_r[k][42:22] * cn4_r[k][42:22];
        hl5_r[k]  <= cn4_r[k][42:22] * cn4_r[k][21:0];
        ll5_r[k]  <= cn4_r[k][21:0] * cn4_r[k][21:0];
        es5_r[k]  <= es4_r[k];
        cen5_r[k] <= cen4_r[k];
      end

      for (int k = 0; k < 3; k++) begin
        csq6_r[k] <= {hh5_r[k], 44'b0} + {20'b0, hl5_r[k], 23'b0} + {42'b0, ll5_r[k]};
        es6_r[k]  <= es5_r[k];
        cen6_r[k] <= cen5_r[k];
      end

      s7_r <= csq6_r[0] + csq6_r[1] + csq6_r[2];
      for (int k = 0; k < 3; k++) begin
        es7_r[k]  <= es6_r[k];
        cen7_r[k] <= cen6_r[k];
      end
    end
  end

  tqm_isqrt u_isq_area (
    .clk      (clk),
    .en       (en),
    .sq_in    (s7_r),
    .root_out (area_root)
  );

  // Edge lengths carry 8 fraction bits: root of the squared length times 2^16.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    tqm_isqrt u_isq_edge (
      .clk      (clk),
      .en       (en),
      .sq_in    ({28'b0, es7_r[e], 16'b0}),
      .root_out (len_root[e])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cen_dly_r[0] <= cen7_r;
      for (int k = 1; k < TQM_ROOT_W; k++) begin
        cen_dly_r[k] <= cen_dly_r[k-1];
      end
    end
  end

  assign ak_sum = {1'b0, khi1_r, 22'b0} + {22'b0, klo1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      per1_r <= {2'b0, len_root[0][TQM_LEN_W-1:0]} + {2'b0, len_root[1][TQM_LEN_W-1:0]}
              + {2'b0, len_root[2][TQM_LEN_W-1:0]};
      klo1_r <= area_root[21:0] * TQM_QUALITY_K;
      khi1_r <= area_root[42:22] * TQM_QUALITY_K;
      side1_r.cen   <= cen_dly_r[TQM_ROOT_W-1];
      side1_r.twice <= area_root;
      side1_r.degen <= 1'b0;

      den2_r <= per1_r * per1_r;
      num2_r <= {ak_sum, 16'b0};
      side2_r.cen   <= side1_r.cen;
      side2_r.twice <= side1_r.twice;
      side2_r.degen <= per1_r == '0;
    end
  end

  tqm_divider u_div (
    .clk     (clk),
    .en      (en),
    .num_in  (num2_r),
    .den_in  (den2_r),
    .quo_out (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly_r[0] <= side2_r;
      for (int k = 1; k < TQM_DIV_STAGES; k++) begin
        side_dly_r[k] <= side_dly_r[k-1];
      end
    end
  end

  assign qual = side_dly_r[TQM_DIV_STAGES-1].degen ? '0 : quo;

  always_ff @(posedge clk) begin
    if (en) begin
      cen_o_r   <= side_dly_r[TQM_DIV_STAGES-1].cen;
      area_o_r  <= {1'b0, side_dly_r[TQM_DIV_STAGES-1].twice};
      quality_r <= qual;
      lowq_r    <= qual < thr_r;
      degen_r   <= side_dly_r[TQM_DIV_STAGES-1].degen;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, quality_r, area_o_r, cen_o_r[2], cen_o_r[1], cen_o_r[0]};
  assign out_tuser  = {degen_r, lowq_r};

  `TQM_ASSERT_HOLD(a_degen_zero, clk, rst_n, out_tvalid_r && degen_r, quality_r == '0 && area_o_r == '0, "degenerate item has nonzero quality or area")
  `TQM_ASSERT_HOLD(a_quality_range, clk, rst_n, out_tvalid_r, quality_r <= TQM_QUALITY_ONE, "quality above one")
  `TQM_ASSERT_NEXT(a_stall_freeze, clk, rst_n, out_tvalid_r && !out_tready, out_tvalid_r && $stable(vld_r), "pipeline moved while the output was stalled")

endmodule

// File: rtl/tqm_isqrt.sv
module tqm_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tqm_pkg::TQM_SQ_W-1:0]   sq_in,
  output logic [tqm_pkg::TQM_ROOT_W-1:0] root_out
);
  import tqm_pkg::*;

  // One result bit per stage, restoring digit-by-digit square root.
  logic [TQM_ROOT_W-1:0] root_r [TQM_ROOT_W];
  logic [TQM_ROOT_W+1:0] rem_r  [TQM_ROOT_W-1];
  logic [TQM_SQ_W-1:0]   op_r   [TQM_ROOT_W-1];

  for (genvar k = 0; k < TQM_ROOT_W; k++) begin : g_stage
    logic [TQM_ROOT_W+1:0] rem_in;
    logic [TQM_ROOT_W+1:0] rem_sh;
    logic [TQM_ROOT_W+1:0] trial;
    logic [TQM_ROOT_W+1:0] rem_nxt;
    logic [TQM_ROOT_W-1:0] root_in;
    logic [TQM_ROOT_W-1:0] root_nxt;
    logic [TQM_SQ_W-1:0]   op_in;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign op_in   = sq_in;
    end else begin : g_rest
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign op_in   = op_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[TQM_ROOT_W-1:0], op_in[TQM_SQ_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[TQM_ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[TQM_ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_nxt;
      end
    end

    if (k < TQM_ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          op_r[k]  <= op_in << 2;
        end
      end
    end
  end

  assign root_out = root_r[TQM_ROOT_W-1];

endmodule

// File: rtl/tqm_divider.sv
module tqm_divider (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tqm_pkg::TQM_NUM_W-1:0]  num_in,
  input  logic [tqm_pkg::TQM_DEN_W-1:0]  den_in,
  output logic [tqm_pkg::TQM_QBITS-1:0]  quo_out
);
  import tqm_pkg::*;

  // The first stage flags quotients of 2^QBITS or more, the rest produce
  // one quotient bit each from the top down.
  logic [TQM_QBITS-1:0] quo_r [TQM_DIV_STAGES];
  logic                 ovf_r [TQM_DIV_STAGES];
  logic [TQM_REM_W-1:0] rem_r [TQM_QBITS];
  logic [TQM_DEN_W-1:0] den_r [TQM_QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, num_in};
      den_r[0] <= den_in;
      ovf_r[0] <= {1'b0, num_in} >= {den_in, {TQM_QBITS{1'b0}}};
      quo_r[0] <= '0;
    end
  end

  for (genvar j = 1; j < TQM_DIV_STAGES; j++) begin : g_stage
    logic [TQM_REM_W-1:0] trial;
    logic                 ge;

    assign trial = {{TQM_QBITS{1'b0}}, den_r[j-1]} << (TQM_QBITS - j);
    assign ge    = rem_r[j-1] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= quo_r[j-1] | (TQM_QBITS'(ge) << (TQM_QBITS - j));
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < TQM_QBITS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (rem_r[j-1] - trial) : rem_r[j-1];
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  assign quo_out = (ovf_r[TQM_DIV_STAGES-1] ||
                    quo_r[TQM_DIV_STAGES-1] > TQM_QUALITY_ONE) ?
                   TQM_QUALITY_ONE : quo_r[TQM_DIV_STAGES-1];

endmodule
